/* rtl/window_run_length_nonuniformity_top_assert.svh */
// Assertion macros shared by the window run-length nonuniformity block.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef WINDOW_RUN_LENGTH_NONUNIFORMITY_TOP_ASSERT_SVH
`define WINDOW_RUN_LENGTH_NONUNIFORMITY_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define WRLN_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("window run-length check failed");

`define WRLN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("window run-length check failed");

`else

`define WRLN_ASSERT_SAME(label, ante, cons)

`define WRLN_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/wrln_pkg.sv */
package wrln_pkg;

	typedef logic [3:0] nu_t;
	typedef logic [1:0] rcnt_t;

	typedef enum logic {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_index_t;

	// Result for a window with k1 rows of three distinct levels and k2 rows
	// holding one pair; the remaining rows are uniform. This is the floored
	// quotient (n1^2 + n2^2 + n3^2) / (n1 + n2 + n3) for each mix of rows.
	function automatic nu_t nu_lookup(rcnt_t k1, rcnt_t k2);
		nu_t r;
		case ({k1, k2})
			4'b11_00: r = 4'd9;
			4'b10_01: r = 4'd6;
			4'b10_00: r = 4'd5;
			4'b01_10: r = 4'd4;
			4'b01_01: r = 4'd3;
			4'b01_00: r = 4'd2;
			4'b00_11: r = 4'd3;
			4'b00_10: r = 4'd1;
			4'b00_01: r = 4'd1;
			4'b00_00: r = 4'd3;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/wrln_ram.sv */
module wrln_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/wrln_kernel.sv */
module wrln_kernel import wrln_pkg::*; #(
	parameter int PIXEL_BITS = 8
) (
	input  logic [PIXEL_BITS-1:0] col_a [3],
	input  logic [PIXEL_BITS-1:0] col_b [3],
	input  logic [PIXEL_BITS-1:0] col_c [3],
	output nu_t                   nonuniformity
);

	logic [2:0] distinct;
	logic [2:0] paired;
	rcnt_t      k1;
	rcnt_t      k2;

	// Classify each window row: all three equal, one pair of neighbors, or
	// three runs of length one.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			distinct[i] = (col_a[i] != col_b[i]) && (col_b[i] != col_c[i]);
			paired[i]   = !distinct[i] &&
				!((col_a[i] == col_b[i]) && (col_b[i] == col_c[i]));
		end
		k1 = 2'(distinct[0]) + 2'(distinct[1]) + 2'(distinct[2]);
		k2 = 2'(paired[0]) + 2'(paired[1]) + 2'(paired[2]);
		nonuniformity = nu_lookup(k1, k2);
	end

endmodule

/* rtl/window_run_length_nonuniformity_top.sv */
// Channel   Direction  Handshake             Contents
// pixel     in         in_valid / in_stall   pixel
// result    out        out_valid / out_stall center_row, center_col, nonuniformity,
//                                            frame_last
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A pixel's column is read from the line store RAM when it is accepted in ST_IDLE;
// in ST_CALC the window is updated and the column is written back to the same entry.
// A request is taken while a result still waits in the output register; it only
// holds in ST_CALC if it produces a result and that register is still full and stalled.
// Reset clears the counters, the window and the output valid; the line store needs
// no clearing. Configuration writes are always ready.
module window_run_length_nonuniformity_top import wrln_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] center_row,
	output logic [9:0]  center_col,
	output logic [3:0]  nonuniformity,
	output logic        frame_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	`include "window_run_length_nonuniformity_top_assert.svh"

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int DW = 2 * PIXEL_BITS;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CALC = 1'b1;

	logic                  state_q;
	logic [10:0]           frame_width_q;
	logic [15:0]           frame_height_q;
	logic [CW-1:0]         col_q;
	logic [15:0]           row_q;
	logic [PIXEL_BITS-1:0] win_q [6];
	logic [PIXEL_BITS-1:0] px_s1;

	logic                  out_valid_q;
	logic [15:0]           center_row_q;
	logic [9:0]            center_col_q;
	nu_t                   nu_q;
	logic                  frame_last_q;

	logic                  in_accept;
	logic [DW-1:0]         ram_rdata;
	logic [PIXEL_BITS-1:0] up;
	logic [PIXEL_BITS-1:0] mid;
	logic [WW-1:0]         w_eff;
	logic [WW-1:0]         last_col;
	logic [15:0]           last_row;
	logic                  row_end;
	logic                  frame_end;
	logic                  emit;
	logic                  finish;
	nu_t                   nu;
	logic [PIXEL_BITS-1:0] col_a [3];
	logic [PIXEL_BITS-1:0] col_b [3];
	logic [PIXEL_BITS-1:0] col_c [3];

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q == ST_CALC);
	assign in_accept = in_valid && !in_stall;

	assign up  = ram_rdata[DW-1:PIXEL_BITS];
	assign mid = ram_rdata[PIXEL_BITS-1:0];

	always_comb begin
		if (frame_width_q < 11'd3) begin
			w_eff = WW'(3);
		end else if (int'(frame_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width_q);
		end
		last_col  = w_eff - 1'b1;
		last_row  = (frame_height_q < 16'd3) ? 16'd2 : frame_height_q - 16'd1;
		row_end   = {1'b0, col_q} >= last_col;
		frame_end = row_end && (row_q >= last_row);
		emit      = (row_q >= 16'd2) && (int'(col_q) >= 2);
		// The item completes unless its result would overwrite one still waiting.
		finish    = (state_q == ST_CALC) && !(emit && out_valid_q && out_stall);
	end

	assign col_a[0] = win_q[0];
	assign col_a[1] = win_q[1];
	assign col_a[2] = win_q[2];
	assign col_b[0] = win_q[3];
	assign col_b[1] = win_q[4];
	assign col_b[2] = win_q[5];
	assign col_c[0] = up;
	assign col_c[1] = mid;
	assign col_c[2] = px_s1;

	wrln_kernel #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_kernel (
		.col_a        (col_a),
		.col_b        (col_b),
		.col_c        (col_c),
		.nonuniformity(nu)
	);

	// Each entry holds the column's upper and middle pixels; the read at
	// acceptance and the write-back at completion never overlap in time.
	wrln_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (finish),
		.waddr(col_q),
		.wdata({mid, px_s1}),
		.re   (in_accept),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 11'd640;
			frame_height_q <= 16'd480;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH:  frame_width_q  <= cfg_data[10:0];
				CFG_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (finish) begin
						state_q  <= ST_IDLE;
						win_q[0] <= win_q[3];
						win_q[1] <= win_q[4];
						win_q[2] <= win_q[5];
						win_q[3] <= up;
						win_q[4] <= mid;
						win_q[5] <= px_s1;
						if (row_end) begin
							col_q <= '0;
							row_q <= frame_end ? 16'd0 : row_q + 16'd1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			px_s1 <= PIXEL_BITS'(pixel);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && emit) begin
			center_row_q <= row_q - 16'd1;
			center_col_q <= 10'(col_q - 1'b1);
			nu_q         <= nu;
			frame_last_q <= frame_end;
		end
	end

	assign out_valid     = out_valid_q;
	assign center_row    = center_row_q;
	assign center_col    = center_col_q;
	assign nonuniformity = nu_q;
	assign frame_last    = frame_last_q;

	`WRLN_ASSERT_NEXT(a_accept_enters_calc, in_accept, state_q == ST_CALC)
	`WRLN_ASSERT_SAME(a_result_in_range, out_valid, (nu_q != 4'd0) && (nu_q <= 4'd9))
	`WRLN_ASSERT_SAME(a_result_from_calc, $rose(out_valid_q), $past(state_q) == ST_CALC)

endmodule

/* tb/sv/tb.sv */
module tb import wrln_pkg::*;;

	localparam int MAX_WIDTH = 1024;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 400;

	typedef enum int {
		STYLE_NOISE,
		STYLE_TWO_LEVELS,
		STYLE_THREE_LEVELS,
		STYLE_FLAT
	} pix_style_t;

	typedef struct packed {
		logic [15:0] row;
		logic [9:0]  col;
		nu_t         nu;
		logic        last;
	} window_result_t;

	typedef struct packed {
		logic [7:0]     px;
		logic           known;
		window_result_t want;
	} dir_row_t;

	typedef struct packed {
		logic [15:0] w_cfg;
		logic [15:0] h_cfg;
		int          frames;
		int          cut_rows;
		int          send_pct;
		int          recv_pct;
		logic        hold;
	} phase_t;

	// Two 3x3 frames with both registers below range: a flat frame and one where
	// every row holds three distinct levels.
	localparam dir_row_t DIRECTED [18] = '{
		'{8'd255, 1'b0, '0},
		'{8'd255, 1'b0, '0},
		'{8'd255, 1'b0, '0},
		'{8'd255, 1'b0, '0},
		'{8'd255, 1'b0, '0},
		'{8'd255, 1'b0, '0},
		'{8'd255, 1'b0, '0},
		'{8'd255, 1'b0, '0},
		'{8'd255, 1'b1, '{16'd1, 10'd1, 4'd3, 1'b1}},
		'{8'd0,   1'b0, '0},
		'{8'd128, 1'b0, '0},
		'{8'd255, 1'b0, '0},
		'{8'd1,   1'b0, '0},
		'{8'd2,   1'b0, '0},
		'{8'd4,   1'b0, '0},
		'{8'd8,   1'b0, '0},
		'{8'd16,  1'b0, '0},
		'{8'd32,  1'b1, '{16'd1, 10'd1, 4'd9, 1'b1}}
	};

	localparam phase_t PHASES [8] = '{
		'{16'd3,     16'd3,     6,  0, 34, 84, 1'b0},
		'{16'd7,     16'd5,     2,  0, 34, 84, 1'b1},
		'{16'd1,     16'd0,     3,  0, 34, 84, 1'b0},
		'{16'd16,    16'd6,     1,  0, 84, 34, 1'b0},
		'{16'd12,    16'hFFFF,  0,  3, 84, 34, 1'b0},
		'{16'd9,     16'd7,     1,  0, 84, 34, 1'b0},
		'{16'hFFFF,  16'd3,     0,  1, 0,  0,  1'b0},
		'{16'd5,     16'd4,     1,  0, 0,  0,  1'b0}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  pixel = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] center_row;
	logic [9:0]  center_col;
	nu_t         nonuniformity;
	logic        frame_last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_WIDTH;
	logic [15:0] cfg_data = '0;

	// Own copy of the block state.
	logic [7:0]  upper_line [MAX_WIDTH] = '{default: '0};
	logic [7:0]  middle_line [MAX_WIDTH] = '{default: '0};
	logic [7:0]  window_cols [6] = '{default: '0};
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	logic [10:0] cfg_width = 11'd640;
	logic [15:0] cfg_height = 16'd480;

	window_result_t pending_windows [$];
	int mismatches = 0;
	int send_idle_pct = 34;
	int recv_idle_pct = 84;
	bit hold_req = 1'b0;
	int hold_left = 0;

	window_run_length_nonuniformity_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pixel         (pixel),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.center_row    (center_row),
		.center_col    (center_col),
		.nonuniformity (nonuniformity),
		.frame_last    (frame_last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned eff_width();
		int unsigned w;
		w = cfg_width;
		if (w < 3) w = 3;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned eff_height();
		return (cfg_height < 3) ? 3 : cfg_height;
	endfunction

	function automatic void tally_runs(input logic [7:0] a, b, c,
			inout int unsigned singles, pairs, triples);
		if (a == b && b == c) begin
			triples++;
		end else if (a == b || b == c) begin
			pairs++;
			singles++;
		end else begin
			singles += 3;
		end
	endfunction

	// Advances the window by one pixel; returns 1 when the pixel completes an
	// interior window.
	function automatic bit window_nonuniformity(input logic [7:0] px,
			output window_result_t res);
		int unsigned w, h, singles, pairs, triples, num, den;
		logic [7:0] up, mid;
		bit row_end, frame_end, hit;
		w = eff_width();
		h = eff_height();
		up = upper_line[col_pos];
		mid = middle_line[col_pos];
		upper_line[col_pos] = mid;
		middle_line[col_pos] = px;
		row_end = (col_pos >= w - 1);
		frame_end = row_end && (row_pos >= h - 1);
		hit = (row_pos >= 2) && (col_pos >= 2);
		res = '0;
		if (hit) begin
			singles = 0;
			pairs = 0;
			triples = 0;
			tally_runs(window_cols[0], window_cols[3], up, singles, pairs, triples);
			tally_runs(window_cols[1], window_cols[4], mid, singles, pairs, triples);
			tally_runs(window_cols[2], window_cols[5], px, singles, pairs, triples);
			num = singles * singles + pairs * pairs + triples * triples;
			den = singles + pairs + triples;
			res.row = 16'(row_pos - 1);
			res.col = 10'(col_pos - 1);
			res.nu = nu_t'(num / den);
			res.last = frame_end;
		end
		window_cols[0] = window_cols[3];
		window_cols[1] = window_cols[4];
		window_cols[2] = window_cols[5];
		window_cols[3] = up;
		window_cols[4] = mid;
		window_cols[5] = px;
		if (row_end) begin
			col_pos = 0;
			row_pos = frame_end ? 0 : ((row_pos + 1) & 32'hFFFF);
		end else begin
			col_pos = col_pos + 1;
		end
		return hit;
	endfunction

	task automatic send_pixel(input logic [7:0] px, input logic known,
			input window_result_t given);
		window_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (window_nonuniformity(px, res)) begin
			pending_windows.push_back(known ? given : res);
		end
	endtask

	task automatic send_rows(input int rows);
		pix_style_t style;
		logic [7:0] lv0, lv1, lv2, px;
		int n;
		style = pix_style_t'($urandom_range(3));
		lv0 = 8'($urandom_range(255));
		lv1 = 8'($urandom_range(255));
		lv2 = 8'($urandom_range(255));
		n = rows * eff_width();
		for (int i = 0; i < n; i++) begin
			case (style)
				STYLE_NOISE: px = 8'($urandom_range(255));
				STYLE_TWO_LEVELS: px = $urandom_range(1) ? lv0 : lv1;
				STYLE_THREE_LEVELS: begin
					case ($urandom_range(2))
						0: px = lv0;
						1: px = lv1;
						default: px = lv2;
					endcase
				end
				default: px = ($urandom_range(7) == 0) ? lv1 : lv0;
			endcase
			send_pixel(px, 1'b0, '0);
		end
	endtask

	// Waits until every expected result is out, then lets the pipeline empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The caller lowers cfg_valid after its last write.
	task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_WIDTH) begin
			cfg_width = val[10:0];
		end else begin
			cfg_height = val;
		end
	endtask

	initial begin
		window_result_t want;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_windows.size() == 0) begin
					$error("result at row %0d col %0d with no window pending",
						center_row, center_col);
					mismatches++;
				end else begin
					want = pending_windows.pop_front();
					if (center_row !== want.row) begin
						$error("center_row: expected %0d, got %0d", want.row, center_row);
						mismatches++;
					end
					if (center_col !== want.col) begin
						$error("center_col: expected %0d, got %0d", want.col, center_col);
						mismatches++;
					end
					if (nonuniformity !== want.nu) begin
						$error("nonuniformity: expected %0d, got %0d", want.nu,
							nonuniformity);
						mismatches++;
					end
					if (frame_last !== want.last) begin
						$error("frame_last: expected %0d, got %0d", want.last, frame_last);
						mismatches++;
					end
				end
			end
			// A long hold-off lets the block fill up and stall its input.
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	initial begin
		phase_t ph;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_WIDTH, 16'd0);
		write_reg(CFG_HEIGHT, 16'd2);
		cfg_valid <= 1'b0;
		@(posedge clk);
		for (int k = 0; k < $size(DIRECTED); k++) begin
			send_pixel(DIRECTED[k].px, DIRECTED[k].known, DIRECTED[k].want);
		end

		// Settings change at frame boundaries, or mid-frame only to shrink, so no result
		// uses a line store entry that the current frame has not written.
		for (int p = 0; p < $size(PHASES); p++) begin
			ph = PHASES[p];
			settle();
			send_idle_pct = ph.send_pct;
			recv_idle_pct = ph.recv_pct;
			write_reg(CFG_WIDTH, ph.w_cfg);
			write_reg(CFG_HEIGHT, ph.h_cfg);
			cfg_valid <= 1'b0;
			@(posedge clk);
			if (ph.hold) hold_req = 1'b1;
			repeat (ph.frames) send_rows(eff_height());
			if (ph.cut_rows != 0) begin
				// Shrinking both registers mid-frame ends the frame within a few
				// narrow rows.
				send_rows(ph.cut_rows);
				settle();
				write_reg(CFG_WIDTH, 16'd3);
				write_reg(CFG_HEIGHT, 16'd3);
				cfg_valid <= 1'b0;
				@(posedge clk);
				send_rows((row_pos >= eff_height() - 1) ? 1 : int'(eff_height() - row_pos));
			end
		end

		settle();
		if (mismatches == 0 && pending_windows.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#10000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
